// File: src/sm4ce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm4ce_pkg
// Shared types, constants and round functions of the SM4-CBC encrypt engine.
// ----------------------------------------------------------------------------
package sm4ce_pkg;

  localparam int NUM_ROUNDS = 32;
  localparam int ROUND_W    = $clog2(NUM_ROUNDS);
  localparam int CNT_W      = $clog2(NUM_ROUNDS + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [31:0] FK0 = 32'hA3B1BAC6;
  localparam logic [31:0] FK1 = 32'h56AA3350;
  localparam logic [31:0] FK2 = 32'h677D9197;
  localparam logic [31:0] FK3 = 32'hB27022DC;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_HIGH = 2'd0,
    CFG_KEY_LOW  = 2'd1,
    CFG_IV_HIGH  = 2'd2,
    CFG_IV_LOW   = 2'd3
  } cfg_idx_t;

  // controller to datapath commands
  typedef struct packed {
    logic               load;
    logic               key_step;
    logic               data_step;
    logic               finish;
    logic [ROUND_W-1:0] round;
  } cmd_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
    8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
    8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
    8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
    8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
    8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
    8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
    8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
    8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
    8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
    8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
    8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
    8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
    8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
    8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
  };

  function automatic logic [31:0] tau(input logic [31:0] x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  // round transform L: rotations 2, 10, 18, 24
  function automatic logic [31:0] round_t(input logic [31:0] x);
    logic [31:0] b;
    b = tau(x);
    return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]} ^ {b[13:0], b[31:14]} ^
           {b[7:0], b[31:8]};
  endfunction

  // key schedule transform L': rotations 13, 23
  function automatic logic [31:0] key_t(input logic [31:0] x);
    logic [31:0] b;
    b = tau(x);
    return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
  endfunction

  // ck byte j = (4i + j) * 7 mod 256
  function automatic logic [31:0] ck_word(input logic [ROUND_W-1:0] i);
    logic [31:0]        w;
    logic [ROUND_W+1:0] idx;
    logic [ROUND_W+4:0] prod;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      idx  = {i, 2'(j)};
      prod = {3'b000, idx} * (ROUND_W + 5)'(7);
      w    = {w[23:0], prod[7:0]};
    end
    return w;
  endfunction

endpackage

// File: src/sm4ce_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm4ce_ctrl
// Sequencer: takes a transaction, steps the rounds, hands the
// result to the output register.
// ----------------------------------------------------------------------------
module sm4ce_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output sm4ce_pkg::cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } state_t;

  state_t                          state_r;
  logic [sm4ce_pkg::CNT_W-1:0]     cnt_r;
  logic                            out_valid_r;
  logic                            out_free;
  logic                            accept;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    cmd           = '0;
    cmd.round     = cnt_r[sm4ce_pkg::ROUND_W-1:0];
    cmd.load      = accept;
    // key round i runs in the cycle before data round i
    cmd.key_step  = (state_r == S_RUN) &&
                    (cnt_r < sm4ce_pkg::CNT_W'(sm4ce_pkg::NUM_ROUNDS));
    cmd.data_step = (state_r == S_RUN) && (cnt_r != '0);
    cmd.finish    = (state_r == S_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_RUN;
            cnt_r   <= '0;
          end
        end
        S_RUN: begin
          if (cnt_r == sm4ce_pkg::CNT_W'(sm4ce_pkg::NUM_ROUNDS)) begin
            state_r <= S_FIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/sm4ce_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm4ce_dp
// Datapath: key and iv registers, round key unit, data round unit,
// chain value and output register.
// ----------------------------------------------------------------------------
module sm4ce_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [sm4ce_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sm4ce_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [63:0]                          in_plain_high,
  input  logic [63:0]                          in_plain_low,
  input  logic                                 in_restart_chain,
  input  sm4ce_pkg::cmd_t                      cmd,
  output logic [63:0]                          out_cipher_high,
  output logic [63:0]                          out_cipher_low
);

  logic [63:0] key_high_r, key_low_r, iv_high_r, iv_low_r;
  logic [63:0] chain_high_r, chain_low_r;
  logic [63:0] out_high_r, out_low_r;
  logic [31:0] k0_r, k1_r, k2_r, k3_r;
  logic [31:0] x0_r, x1_r, x2_r, x3_r;
  logic [31:0] rk_r;
  logic [31:0] nk_nxt, nx_nxt;
  logic [63:0] src_high, src_low;

  assign out_cipher_high = out_high_r;
  assign out_cipher_low  = out_low_r;

  assign src_high = in_restart_chain ? iv_high_r : chain_high_r;
  assign src_low  = in_restart_chain ? iv_low_r  : chain_low_r;

  assign nk_nxt = k0_r ^ sm4ce_pkg::key_t(k1_r ^ k2_r ^ k3_r ^ sm4ce_pkg::ck_word(cmd.round));
  assign nx_nxt = x0_r ^ sm4ce_pkg::round_t(x1_r ^ x2_r ^ x3_r ^ rk_r);

  // configuration and chain state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r   <= '0;
      key_low_r    <= '0;
      iv_high_r    <= '0;
      iv_low_r     <= '0;
      chain_high_r <= '0;
      chain_low_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (sm4ce_pkg::cfg_idx_t'(cfg_index))
          sm4ce_pkg::CFG_KEY_HIGH: key_high_r <= cfg_data;
          sm4ce_pkg::CFG_KEY_LOW:  key_low_r  <= cfg_data;
          sm4ce_pkg::CFG_IV_HIGH:  iv_high_r  <= cfg_data;
          sm4ce_pkg::CFG_IV_LOW:   iv_low_r   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.finish) begin
        chain_high_r <= {x3_r, x2_r};
        chain_low_r  <= {x1_r, x0_r};
      end
    end
  end

  // round registers and output payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k0_r <= key_high_r[63:32] ^ sm4ce_pkg::FK0;
      k1_r <= key_high_r[31:0]  ^ sm4ce_pkg::FK1;
      k2_r <= key_low_r[63:32]  ^ sm4ce_pkg::FK2;
      k3_r <= key_low_r[31:0]   ^ sm4ce_pkg::FK3;
      x0_r <= in_plain_high[63:32] ^ src_high[63:32];
      x1_r <= in_plain_high[31:0]  ^ src_high[31:0];
      x2_r <= in_plain_low[63:32]  ^ src_low[63:32];
      x3_r <= in_plain_low[31:0]   ^ src_low[31:0];
    end else begin
      if (cmd.key_step) begin
        k0_r <= k1_r;
        k1_r <= k2_r;
        k2_r <= k3_r;
        k3_r <= nk_nxt;
        rk_r <= nk_nxt;
      end
      if (cmd.data_step) begin
        x0_r <= x1_r;
        x1_r <= x2_r;
        x2_r <= x3_r;
        x3_r <= nx_nxt;
      end
    end
    // output words in reverse order
    if (cmd.finish) begin
      out_high_r <= {x3_r, x2_r};
      out_low_r  <= {x1_r, x0_r};
    end
  end

endmodule

// File: src/sm4_cbc_encrypt_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm4_cbc_encrypt_engine_unit
// SM4-CBC encryption of one 128-bit block per transaction.
// After input accept, the key round unit and the data round unit step the
//   rounds, each key round ahead of its data round, and the result is then
//   loaded into the output register, which raises out_valid. The next block
//   is not accepted until then, as it waits on the chain.
// Reset (rst_n low, synchronous): key, iv and chain value cleared, idle.
// ----------------------------------------------------------------------------
module sm4_cbc_encrypt_engine_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [sm4ce_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sm4ce_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [63:0]                          in_plain_high,
  input  logic [63:0]                          in_plain_low,
  input  logic                                 in_restart_chain,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [63:0]                          out_cipher_high,
  output logic [63:0]                          out_cipher_low
);

  sm4ce_pkg::cmd_t cmd;

  sm4ce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  sm4ce_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_plain_high    (in_plain_high),
    .in_plain_low     (in_plain_low),
    .in_restart_chain (in_restart_chain),
    .cmd              (cmd),
    .out_cipher_high  (out_cipher_high),
    .out_cipher_low   (out_cipher_low)
  );

endmodule
